// ===== hw/rtl/drfp_pkg.sv =====
`default_nettype none

package drfp_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;

    // Frame bytes
    localparam logic [BYTE_W-1:0] BYTE_TERM  = 8'hFF;
    localparam logic [BYTE_W-1:0] TYPE_TOUCH = 8'h65;
    localparam logic [BYTE_W-1:0] TYPE_PAGE  = 8'h66;

    // Total frame lengths, terminator included
    localparam logic [LEN_W-1:0] TOUCH_LEN = 6'd7;
    localparam logic [LEN_W-1:0] PAGE_LEN  = 6'd5;
    localparam logic [LEN_W-1:0] TERM_LEN  = 6'd3;
    localparam logic [LEN_W-1:0] HDR_LEN   = 6'd4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TOUCH   = 2'd0,
        KIND_PAGE    = 2'd1,
        KIND_GENERIC = 2'd2
    } kind_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD
    } back_state_t;

    // One decoded frame, handed from front to back
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] page;
        logic [BYTE_W-1:0] component;
        logic [BYTE_W-1:0] touch_event;
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  len;
    } job_t;

    // Frame buffer write port
    typedef struct packed {
        logic              en;
        logic [LEN_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    // One output beat
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] page;
        logic [BYTE_W-1:0] component;
        logic [BYTE_W-1:0] touch_event;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic [LEN_W-1:0]  payload_length;
        logic              last;
    } res_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== hw/rtl/drfp_front.sv =====
`default_nettype none

module drfp_front #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   dispatch,
    input  wire logic                   q_full,
    output logic                        q_push,
    output drfp_pkg::job_t              q_job,
    output drfp_pkg::mem_wr_t           mem_wr,
    input  wire logic                   gen_done
);

    localparam int IDX_W = $clog2(FRAME_DEPTH);

    logic [IDX_W-1:0]             fill_idx_reg, fill_idx_next;
    logic [1:0]                   hist_reg, hist_next;
    logic [drfp_pkg::BYTE_W-1:0]  cur_page_reg, cur_page_next;
    logic [drfp_pkg::BYTE_W-1:0]  type_reg, type_next;
    logic [drfp_pkg::BYTE_W-1:0]  b1_reg, b1_next;
    logic [drfp_pkg::BYTE_W-1:0]  b2_reg, b2_next;
    logic [drfp_pkg::BYTE_W-1:0]  b3_reg, b3_next;
    logic                         hold_reg, hold_next;

    logic                         accept;
    logic                         is_term;
    logic [IDX_W-1:0]             n_idx;
    logic [drfp_pkg::LEN_W-1:0]   n_len;
    logic                         frame_done;
    drfp_pkg::job_t               job;

    // Stall while the queue is full or a payload is still being read out of the buffer
    assign in_ready = !q_full && !hold_reg;
    assign accept   = in_valid && in_ready;
    assign is_term  = (rx_byte == drfp_pkg::BYTE_TERM);

    // Index after this byte is stored
    assign n_idx = (fill_idx_reg == IDX_W'(FRAME_DEPTH - 1)) ? '0
                                                              : fill_idx_reg + IDX_W'(1);
    assign n_len = drfp_pkg::LEN_W'(n_idx);

    // With dispatch set, three terminator bytes in a row since the last index clear
    assign frame_done = dispatch && (n_len >= drfp_pkg::TERM_LEN)
                        && (hist_reg == 2'b11) && is_term;

    // Buffer write
    always_comb
    begin
        mem_wr.en   = accept;
        mem_wr.addr = drfp_pkg::LEN_W'(fill_idx_reg);
        mem_wr.data = rx_byte;
    end

    // Classification
    always_comb
    begin
        fill_idx_next = fill_idx_reg;
        hist_next     = hist_reg;
        cur_page_next = cur_page_reg;
        type_next     = type_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        b3_next       = b3_reg;
        hold_next     = hold_reg;
        q_push        = 1'b0;

        job.kind        = drfp_pkg::KIND_GENERIC;
        job.page        = '0;
        job.component   = '0;
        job.touch_event = '0;
        job.frame_type  = '0;
        job.len         = '0;

        if (gen_done)
        begin
            hold_next = 1'b0;
        end

        if (accept)
        begin
            fill_idx_next = n_idx;
            hist_next     = {hist_reg[0], is_term};

            // keep the header bytes as they go by
            case (fill_idx_reg)
                IDX_W'(0): type_next = rx_byte;
                IDX_W'(1): b1_next   = rx_byte;
                IDX_W'(2): b2_next   = rx_byte;
                IDX_W'(3): b3_next   = rx_byte;
                default:   ;
            endcase

            if (frame_done)
            begin
                fill_idx_next = '0;
                if (type_reg == drfp_pkg::TYPE_TOUCH)
                begin
                    if (n_len == drfp_pkg::TOUCH_LEN)
                    begin
                        q_push          = 1'b1;
                        job.kind        = drfp_pkg::KIND_TOUCH;
                        job.page        = b1_reg;
                        job.component   = b2_reg;
                        job.touch_event = b3_reg;
                    end
                end
                else if (type_reg == drfp_pkg::TYPE_PAGE)
                begin
                    if (n_len == drfp_pkg::PAGE_LEN && b1_reg != cur_page_reg)
                    begin
                        q_push        = 1'b1;
                        cur_page_next = b1_reg;
                        job.kind      = drfp_pkg::KIND_PAGE;
                        job.page      = b1_reg;
                    end
                end
                else
                begin
                    q_push         = 1'b1;
                    job.kind       = drfp_pkg::KIND_GENERIC;
                    job.frame_type = type_reg;
                    // terminator-only frame has an empty payload
                    job.len        = (n_len >= drfp_pkg::HDR_LEN) ? n_len - drfp_pkg::HDR_LEN
                                                                  : '0;
                    if (job.len != '0)
                    begin
                        hold_next = 1'b1;
                    end
                end
            end
        end
    end

    assign q_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg <= '0;
            hist_reg     <= '0;
            cur_page_reg <= '0;
            hold_reg     <= 1'b0;
        end
        else
        begin
            fill_idx_reg <= fill_idx_next;
            hist_reg     <= hist_next;
            cur_page_reg <= cur_page_next;
            hold_reg     <= hold_next;
        end
    end

    // Header bytes need no reset
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        b1_reg   <= b1_next;
        b2_reg   <= b2_next;
        b3_reg   <= b3_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/drfp_queue.sv =====
`default_nettype none

module drfp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire drfp_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output drfp_pkg::job_t      head,
    output logic                empty
);

    localparam int PTR_W = $clog2(drfp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(drfp_pkg::QUEUE_DEPTH + 1);

    drfp_pkg::job_t   entry_reg [drfp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(drfp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(drfp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(drfp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/drfp_back.sv =====
`default_nettype none

module drfp_back #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire drfp_pkg::mem_wr_t mem_wr,
    input  wire logic              q_empty,
    input  wire drfp_pkg::job_t    q_head,
    output logic                   q_pop,
    output logic                   gen_done,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output drfp_pkg::res_t         result
);

    localparam int IDX_W = $clog2(FRAME_DEPTH);

    // Frame buffer
    logic [drfp_pkg::BYTE_W-1:0] mem_reg [FRAME_DEPTH];
    logic [drfp_pkg::BYTE_W-1:0] rd_data_reg;

    drfp_pkg::back_state_t       state_reg, state_next;
    drfp_pkg::job_t              job_reg, job_next;
    logic [drfp_pkg::LEN_W-1:0]  pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    drfp_pkg::res_t              result_reg, result_next;
    logic                        out_free;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem_reg[mem_wr.addr[IDX_W-1:0]] <= mem_wr.data;
        end
        rd_data_reg <= mem_reg[pos_reg[IDX_W-1:0]];
    end

    // Sequencer: events and empty generic frames go straight out, payloads are walked byte by byte
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        q_pop          = 1'b0;
        gen_done       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            drfp_pkg::BK_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    if (q_head.kind == drfp_pkg::KIND_GENERIC && q_head.len != '0)
                    begin
                        pos_next   = drfp_pkg::LEN_W'(1);
                        state_next = drfp_pkg::BK_READ;
                    end
                    else
                    begin
                        out_valid_next             = 1'b1;
                        result_next.kind           = q_head.kind;
                        result_next.page           = q_head.page;
                        result_next.component      = q_head.component;
                        result_next.touch_event    = q_head.touch_event;
                        result_next.frame_type     = q_head.frame_type;
                        result_next.data_byte      = '0;
                        result_next.data_valid     = 1'b0;
                        result_next.payload_length = '0;
                        result_next.last           = 1'b1;
                    end
                end
            end

            drfp_pkg::BK_READ:
            begin
                state_next = drfp_pkg::BK_LOAD;
            end

            drfp_pkg::BK_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    result_next.kind           = drfp_pkg::KIND_GENERIC;
                    result_next.page           = '0;
                    result_next.component      = '0;
                    result_next.touch_event    = '0;
                    result_next.frame_type     = job_reg.frame_type;
                    result_next.data_byte      = rd_data_reg;
                    result_next.data_valid     = 1'b1;
                    result_next.payload_length = job_reg.len;
                    result_next.last           = (pos_reg == job_reg.len);
                    if (pos_reg == job_reg.len)
                    begin
                        gen_done   = 1'b1;
                        state_next = drfp_pkg::BK_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + drfp_pkg::LEN_W'(1);
                        state_next = drfp_pkg::BK_READ;
                    end
                end
            end

            default:
            begin
                state_next = drfp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drfp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/display_response_frame_parser_core.sv =====
// Display response frame parser. Serial bytes are written into a frame buffer
// of FRAME_DEPTH bytes; with dispatch set, a frame ends on three 0xFF bytes and
// is decoded by its first byte into a touch event, a page change or a stream of
// generic payload beats, each beat with the frame type and payload length. A
// byte is taken whenever the input is not stalled. Decoded frames pass through
// a two-entry queue behind which the output register sits, so bytes keep
// flowing while results wait; the input stalls once the queue is full. After a
// generic frame with a nonempty payload the input stalls while the back end
// walks the buffer through its single read port, reading each payload byte
// (BK_READ) and then loading it into the output register (BK_LOAD); the stall
// lasts longer if out_ready is held low or earlier results are still queued.
`default_nettype none

module display_response_frame_parser_core #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       dispatch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      page,
    output logic [7:0]      component,
    output logic [7:0]      touch_event,
    output logic [7:0]      frame_type,
    output logic [7:0]      data_byte,
    output logic            data_valid,
    output logic [5:0]      payload_length,
    output logic            last
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              gen_done;
    drfp_pkg::job_t    q_job;
    drfp_pkg::job_t    q_head;
    drfp_pkg::mem_wr_t mem_wr;
    drfp_pkg::res_t    result;

    drfp_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .dispatch (dispatch),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job),
        .mem_wr   (mem_wr),
        .gen_done (gen_done)
    );

    drfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    drfp_back #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_wr    (mem_wr),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .gen_done  (gen_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Result fields
    assign kind           = result.kind;
    assign page           = result.page;
    assign component      = result.component;
    assign touch_event    = result.touch_event;
    assign frame_type     = result.frame_type;
    assign data_byte      = result.data_byte;
    assign data_valid     = result.data_valid;
    assign payload_length = result.payload_length;
    assign last           = result.last;

endmodule

`default_nettype wire
